@@ rtl/core/mdiom_pkg.sv @@
// mdiom_pkg: shared types and constants for the clause-22 mdio frame master
// used by mdiom_front, mdiom_engine and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mdiom_pkg;

    // frame layout
    localparam int PREAMBLE_BITS_DEF = 32;
    localparam int PREAMBLE_MAX      = 32;
    localparam int TICK_W            = 7;   // holds 2 * (PREAMBLE_MAX + 32) - 1
    localparam int BIT_W             = 6;   // frame bit number
    localparam int BODY_BITS         = 32;  // start, opcode, addresses, turnaround, data

    // frame offsets after the preamble
    localparam logic [BIT_W-1:0] REL_START0 = 6'd0;
    localparam logic [BIT_W-1:0] REL_START1 = 6'd1;
    localparam logic [BIT_W-1:0] REL_OP0    = 6'd2;
    localparam logic [BIT_W-1:0] REL_OP1    = 6'd3;
    localparam logic [BIT_W-1:0] REL_PHY    = 6'd4;
    localparam logic [BIT_W-1:0] REL_REG    = 6'd9;
    localparam logic [BIT_W-1:0] REL_TA0    = 6'd14;
    localparam logic [BIT_W-1:0] REL_TA1    = 6'd15;
    localparam logic [BIT_W-1:0] REL_DATA   = 6'd16;
    localparam logic [BIT_W-1:0] REL_END    = 6'd32;
    localparam logic [BIT_W-1:0] PHY_MSB    = 6'd8;   // REL_PHY + 4
    localparam logic [BIT_W-1:0] REG_MSB    = 6'd13;  // REL_REG + 4
    localparam logic [BIT_W-1:0] DATA_MSB   = 6'd31;  // REL_DATA + 15

    // opcode field codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // field widths
    localparam int ADDR_W = 5;
    localparam int WORD_W = 16;

    // stream widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic              start;
        logic              opcode;
        logic [ADDR_W-1:0] reg_addr;
        logic [WORD_W-1:0] wdata;
        logic              mdio_in;
    } t_tick;

    typedef struct packed {
        logic              mdc;
        logic              mdio_out;
        logic              mdio_drive;
        logic              busy;
        logic [WORD_W-1:0] read_data;
        logic              done;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/mdio_management_frame_master_unit.sv @@
// a tick word passes through the front queue, then the engine's output register
// one word per cycle unless output stalls or no word is queued; a frame is 2*(PREAMBLE_BITS+32) words
// the front queue (4 words) lets input and output stall independently
// reset (synchronous, active low): idle, queue empty, phy address and read word 0
// depends on mdiom_pkg, mdiom_front, mdiom_engine
`timescale 1ns / 1ps
`default_nettype none

module mdio_management_frame_master_unit #(
    parameter int PREAMBLE_BITS = mdiom_pkg::PREAMBLE_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [mdiom_pkg::ADDR_W-1:0]        i_cfg_data,     // phy_address
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // start_req, opcode, reg_address[4:0], write_data[15:0], mdio_in
    input  wire  [mdiom_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // mdc, mdio_out, mdio_drive, busy_res, read_data[15:0], zero fill
    output logic [mdiom_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                                o_m_axis_tlast  // done_res
);

    logic [mdiom_pkg::ADDR_W-1:0]   r_phy_address;
    logic                           w_head_valid;
    mdiom_pkg::t_tick               w_head;
    logic                           w_pop;
    mdiom_pkg::t_result             w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phy_address <= '0;
        end else if (i_cfg_valid) begin
            r_phy_address <= i_cfg_data;
        end
    end

    mdiom_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_data       (i_s_axis_tdata),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    mdiom_engine #(
        .PREAMBLE_BITS (PREAMBLE_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (w_head_valid),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_phy_address (r_phy_address),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_result      (w_result)
    );

    assign o_m_axis_tdata = {4'b0000, w_result.read_data, w_result.busy,
                             w_result.mdio_drive, w_result.mdio_out, w_result.mdc};
    assign o_m_axis_tlast = w_result.done;

endmodule

`default_nettype wire

@@ rtl/core/mdiom_front.sv @@
// mdiom_front: accepts tick words and unpacks them into a short queue
// depends on mdiom_pkg
`timescale 1ns / 1ps
`default_nettype none

module mdiom_front (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire  [mdiom_pkg::IN_TDATA_W-1:0]    i_data,
    output logic                                o_head_valid,
    output mdiom_pkg::t_tick                    o_head,
    input  wire                                 i_pop
);

    mdiom_pkg::t_tick                   r_mem [mdiom_pkg::QUEUE_DEPTH];
    logic [mdiom_pkg::QPTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [mdiom_pkg::QPTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [mdiom_pkg::QCNT_W-1:0]       r_count,  n_count;
    mdiom_pkg::t_tick                   w_item;
    logic                               w_push;
    logic                               w_pop;

    // unpack the word, start request in the lowest bit
    always_comb begin
        w_item.start    = i_data[0];
        w_item.opcode   = i_data[1];
        w_item.reg_addr = i_data[6:2];
        w_item.wdata    = i_data[22:7];
        w_item.mdio_in  = i_data[23];
    end

    assign o_ready      = (r_count != mdiom_pkg::QCNT_W'(mdiom_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mdiom_engine.sv @@
// mdiom_engine: frame sequencer, one queued tick per cycle into an output register,
// unless output stalls or no tick is queued; depends on mdiom_pkg
`timescale 1ns / 1ps
`default_nettype none

module mdiom_engine #(
    parameter int PREAMBLE_BITS = mdiom_pkg::PREAMBLE_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_head_valid,
    input  mdiom_pkg::t_tick                    i_head,
    output logic                                o_pop,
    input  wire  [mdiom_pkg::ADDR_W-1:0]        i_phy_address,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output mdiom_pkg::t_result                  o_result
);

    localparam int LastTick = 2 * (PREAMBLE_BITS + mdiom_pkg::BODY_BITS) - 1;

    logic                               r_active,  n_active;
    logic [mdiom_pkg::TICK_W-1:0]       r_tick,    n_tick;
    logic                               r_opcode,  n_opcode;
    logic [mdiom_pkg::ADDR_W-1:0]       r_reg,     n_reg;
    logic [mdiom_pkg::WORD_W-1:0]       r_wword,   n_wword;
    logic [mdiom_pkg::WORD_W-1:0]       r_shift,   n_shift;
    logic                               r_out_valid;
    mdiom_pkg::t_result                 r_out,     n_out;

    logic                               w_take;
    logic                               w_start;
    logic                               w_act;
    logic [mdiom_pkg::TICK_W-1:0]       w_tick;
    logic [mdiom_pkg::BIT_W-1:0]        w_bit;
    logic [mdiom_pkg::BIT_W-1:0]        w_rel;
    logic                               w_high;
    logic                               w_past_pre;
    logic                               w_released;
    logic                               w_level;
    logic [mdiom_pkg::WORD_W-1:0]       w_shift_base;

    assign w_take = i_head_valid && (!r_out_valid || i_ready);
    assign o_pop  = w_take;

    always_comb begin
        w_start      = !r_active && i_head.start;
        w_act        = r_active || w_start;
        w_tick       = w_start ? '0 : r_tick;
        w_bit        = w_tick[mdiom_pkg::TICK_W-1:1];
        w_high       = w_tick[0];
        w_rel        = w_bit - mdiom_pkg::BIT_W'(PREAMBLE_BITS);
        w_past_pre   = (w_bit >= mdiom_pkg::BIT_W'(PREAMBLE_BITS));

        n_opcode     = w_start ? i_head.opcode   : r_opcode;
        n_reg        = w_start ? i_head.reg_addr : r_reg;
        n_wword      = w_start ? i_head.wdata    : r_wword;
        w_shift_base = w_start ? '0 : r_shift;

        w_released   = (n_opcode == mdiom_pkg::OP_READ) && w_past_pre
                       && (w_rel >= mdiom_pkg::REL_TA0);

        // level of a driven frame bit
        if (!w_past_pre) begin
            w_level = 1'b1;
        end else if (w_rel == mdiom_pkg::REL_START0) begin
            w_level = 1'b0;
        end else if (w_rel == mdiom_pkg::REL_START1) begin
            w_level = 1'b1;
        end else if (w_rel == mdiom_pkg::REL_OP0) begin
            w_level = (n_opcode == mdiom_pkg::OP_READ);
        end else if (w_rel == mdiom_pkg::REL_OP1) begin
            w_level = (n_opcode == mdiom_pkg::OP_WRITE);
        end else if (w_rel < mdiom_pkg::REL_REG) begin
            w_level = i_phy_address[3'(mdiom_pkg::PHY_MSB - w_rel)];
        end else if (w_rel < mdiom_pkg::REL_TA0) begin
            w_level = n_reg[3'(mdiom_pkg::REG_MSB - w_rel)];
        end else if (w_rel == mdiom_pkg::REL_TA0) begin
            w_level = 1'b1;
        end else if (w_rel == mdiom_pkg::REL_TA1) begin
            w_level = 1'b0;
        end else if (w_rel < mdiom_pkg::REL_END) begin
            w_level = n_wword[4'(mdiom_pkg::DATA_MSB - w_rel)];
        end else begin
            w_level = 1'b0;
        end

        n_active = r_active;
        n_tick   = r_tick;
        n_shift  = r_shift;
        n_out    = '0;
        n_out.read_data = r_shift;

        if (w_act) begin
            n_shift = w_shift_base;
            // sample the line in the low half of each read data bit
            if (w_released && (w_rel >= mdiom_pkg::REL_DATA) && !w_high) begin
                n_shift = {w_shift_base[mdiom_pkg::WORD_W-2:0], i_head.mdio_in};
            end
            n_out.mdc        = w_high;
            n_out.busy       = 1'b1;
            n_out.mdio_drive = !w_released;
            n_out.mdio_out   = !w_released && w_level;
            n_out.read_data  = n_shift;
            if (w_tick >= mdiom_pkg::TICK_W'(LastTick)) begin
                n_out.done = 1'b1;
                n_active   = 1'b0;
                n_tick     = '0;
            end else begin
                n_active   = 1'b1;
                n_tick     = w_tick + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_tick      <= '0;
            r_opcode    <= 1'b0;
            r_reg       <= '0;
            r_wword     <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_active <= n_active;
                r_tick   <= n_tick;
                r_opcode <= n_opcode;
                r_reg    <= n_reg;
                r_wword  <= n_wword;
                r_shift  <= n_shift;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire
